// ===== hdl/amd_pkg.sv =====
// Shared constants, types and helpers for the affine matrix decomposer.
// No dependencies; every other file in hdl imports this package.
package amd_pkg;

	localparam int DW       = 32;            // field width
	localparam int SQ_W     = 66;            // sum of squares width
	localparam int ROOT_W   = SQ_W / 2;      // integer square root width
	localparam int REM_W    = ROOT_W + 1;    // divider partial remainder
	localparam int QB       = 31;            // quotient bits, values up to 2^30
	localparam int SQRT_LAT = ROOT_W;        // one root bit per stage
	localparam int DIV_LAT  = QB;            // one quotient bit per stage
	localparam int PRE_LAT  = 3;             // abs, square, column sum
	localparam int QUAT_LAT = 5;
	localparam int TOTAL_LAT = PRE_LAT + SQRT_LAT + DIV_LAT + QUAT_LAT + SQRT_LAT + DIV_LAT;

	localparam logic signed [33:0] UNIT_Q30 = 34'sh0_4000_0000;

	typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} branch_t;

	typedef struct packed {
		logic          deg;
		logic [DW-1:0] scale_z;
		logic [DW-1:0] scale_y;
		logic [DW-1:0] scale_x;
		logic [DW-1:0] quat_z;
		logic [DW-1:0] quat_y;
		logic [DW-1:0] quat_x;
		logic [DW-1:0] quat_w;
		logic [DW-1:0] trans_z;
		logic [DW-1:0] trans_y;
		logic [DW-1:0] trans_x;
	} result_t;

	function automatic logic [DW-1:0] abs_fix(input logic [DW-1:0] x);
		abs_fix = x[DW-1] ? (~x + DW'(1)) : x;
	endfunction

endpackage

// ===== hdl/amd_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on amd_pkg.
module amd_sqrt import amd_pkg::*; (
	input  logic              clk,
	input  logic              ce,
	input  logic [SQ_W-1:0]   rad,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0]   rem_s   [SQRT_LAT];
	logic [ROOT_W-1:0] root_s  [SQRT_LAT];
	logic [SQ_W-1:0]   rem_nx  [SQRT_LAT];
	logic [ROOT_W-1:0] root_nx [SQRT_LAT];

	always_comb begin
		logic [SQ_W-1:0]   r_in;
		logic [ROOT_W-1:0] q_in;
		logic [SQ_W:0]     trial;
		int                b;
		for (int k = 0; k < SQRT_LAT; k++) begin
			b = SQRT_LAT - 1 - k;
			if (k == 0) begin
				r_in = rad;
				q_in = '0;
			end else begin
				r_in = rem_s[k-1];
				q_in = root_s[k-1];
			end
			// (root + 2^b)^2 - root^2, with root holding only bits above b
			trial = ((SQ_W+1)'(q_in) << (b + 1)) | ((SQ_W+1)'(1) << (2 * b));
			if ({1'b0, r_in} >= trial) begin
				rem_nx[k]  = SQ_W'({1'b0, r_in} - trial);
				root_nx[k] = q_in | (ROOT_W'(1) << b);
			end else begin
				rem_nx[k]  = r_in;
				root_nx[k] = q_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < SQRT_LAT; k++) begin
				rem_s[k]  <= rem_nx[k];
				root_s[k] <= root_nx[k];
			end
		end
	end

	assign root = root_s[SQRT_LAT-1];

endmodule

// ===== hdl/amd_div.sv =====
// Pipelined fraction divider: trunc(num * 2^30 / den) for num <= den, signed result.
// Depends on amd_pkg. A zero divisor gives zero.
module amd_div import amd_pkg::*; (
	input  logic                 clk,
	input  logic                 ce,
	input  logic [ROOT_W-1:0]    num,
	input  logic                 neg,
	input  logic [ROOT_W-1:0]    den,
	output logic signed [DW-1:0] quo
);

	logic [REM_W-1:0]  r_s   [DIV_LAT];
	logic [ROOT_W-1:0] den_s [DIV_LAT];
	logic [QB-1:0]     q_s   [DIV_LAT];
	logic              neg_s [DIV_LAT];
	logic [REM_W-1:0]  r_nx  [DIV_LAT];
	logic [QB-1:0]     q_nx  [DIV_LAT];
	logic [DW-1:0]     q_mag;

	always_comb begin
		logic [REM_W-1:0]  r_in;
		logic [REM_W-1:0]  diff;
		logic [ROOT_W-1:0] d_in;
		logic [QB-1:0]     q_in;
		for (int k = 0; k < DIV_LAT; k++) begin
			if (k == 0) begin
				r_in = {1'b0, num};
				d_in = den;
				q_in = '0;
			end else begin
				r_in = r_s[k-1];
				d_in = den_s[k-1];
				q_in = q_s[k-1];
			end
			if (r_in >= {1'b0, d_in}) begin
				diff    = r_in - {1'b0, d_in};
				q_nx[k] = q_in | (QB'(1) << (QB - 1 - k));
			end else begin
				diff    = r_in;
				q_nx[k] = q_in;
			end
			// remainder stays below den, so the doubled value fits
			r_nx[k] = diff << 1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < DIV_LAT; k++) begin
				r_s[k] <= r_nx[k];
				q_s[k] <= q_nx[k];
			end
			den_s[0] <= den;
			neg_s[0] <= neg;
			for (int k = 1; k < DIV_LAT; k++) begin
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign q_mag = DW'(q_s[DIV_LAT-1]);

	always_comb begin
		if (den_s[DIV_LAT-1] == '0)
			quo = '0;
		else if (neg_s[DIV_LAT-1])
			quo = -signed'(q_mag);
		else
			quo = signed'(q_mag);
	end

endmodule

// ===== hdl/amd_quat.sv =====
// Quaternion branch selection and vector forming from the unit basis, then sum of squares.
// Depends on amd_pkg. Five register stages.
module amd_quat import amd_pkg::*; (
	input  logic                  clk,
	input  logic                  ce,
	input  logic [8:0][DW-1:0]    n,
	input  logic                  deg_in,
	output logic [SQ_W-1:0]       sum,
	output logic [3:0][DW-1:0]    mag,
	output logic [3:0]            neg,
	output logic                  deg
);

	logic signed [33:0] nn_s1 [9];
	logic signed [33:0] trace_s1;
	branch_t            br_s1;
	logic               deg_s1;

	logic signed [33:0] v_s2 [4];
	logic               clamp_s2;
	logic               deg_s2;

	logic [3:0][DW-1:0] mag_s3;
	logic [3:0]         neg_s3;
	logic               deg_s3;

	logic [2*DW-1:0]    sq_s4 [4];
	logic [3:0][DW-1:0] mag_s4;
	logic [3:0]         neg_s4;
	logic               deg_s4;

	logic [SQ_W-1:0]    sum_s5;
	logic [3:0][DW-1:0] mag_s5;
	logic [3:0]         neg_s5;
	logic               deg_s5;

	logic signed [33:0] ext [9];
	logic signed [33:0] trace;
	branch_t            br;
	logic signed [33:0] rad;
	logic signed [33:0] v_nx [4];

	always_comb begin
		for (int i = 0; i < 9; i++)
			ext[i] = {{2{n[i][DW-1]}}, n[i]};
		trace = ext[0] + ext[4] + ext[8];
		if (trace > 0)
			br = BR_W;
		else if (ext[0] > ext[4] && ext[0] > ext[8])
			br = BR_X;
		else if (ext[4] > ext[8])
			br = BR_Y;
		else
			br = BR_Z;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 9; i++)
				nn_s1[i] <= ext[i];
			trace_s1 <= trace;
			br_s1    <= br;
			deg_s1   <= deg_in;
		end
	end

	// index map: 0 xx, 1 xy, 2 xz, 3 yx, 4 yy, 5 yz, 6 zx, 7 zy, 8 zz
	always_comb begin
		case (br_s1)
			BR_W: begin
				rad     = UNIT_Q30 + trace_s1;
				v_nx[0] = rad;
				v_nx[1] = nn_s1[5] - nn_s1[7];
				v_nx[2] = nn_s1[6] - nn_s1[2];
				v_nx[3] = nn_s1[1] - nn_s1[3];
			end
			BR_X: begin
				rad     = UNIT_Q30 + nn_s1[0] - nn_s1[4] - nn_s1[8];
				v_nx[0] = nn_s1[5] - nn_s1[7];
				v_nx[1] = rad;
				v_nx[2] = nn_s1[3] + nn_s1[1];
				v_nx[3] = nn_s1[6] + nn_s1[2];
			end
			BR_Y: begin
				rad     = UNIT_Q30 + nn_s1[4] - nn_s1[0] - nn_s1[8];
				v_nx[0] = nn_s1[6] - nn_s1[2];
				v_nx[1] = nn_s1[3] + nn_s1[1];
				v_nx[2] = rad;
				v_nx[3] = nn_s1[7] + nn_s1[5];
			end
			default: begin
				rad     = UNIT_Q30 + nn_s1[8] - nn_s1[0] - nn_s1[4];
				v_nx[0] = nn_s1[1] - nn_s1[3];
				v_nx[1] = nn_s1[6] + nn_s1[2];
				v_nx[2] = nn_s1[7] + nn_s1[5];
				v_nx[3] = rad;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 4; i++)
				v_s2[i] <= v_nx[i];
			clamp_s2 <= (rad <= 0);
			deg_s2   <= deg_s1;
		end
	end

	// halving toward zero is a shift of the magnitude
	always_ff @(posedge clk) begin
		logic [33:0] a;
		if (ce) begin
			for (int i = 0; i < 4; i++) begin
				a = v_s2[i][33] ? 34'(-v_s2[i]) : 34'(v_s2[i]);
				mag_s3[i] <= clamp_s2 ? '0 : a[DW:1];
				neg_s3[i] <= v_s2[i][33];
			end
			deg_s3 <= deg_s2 | clamp_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 4; i++)
				sq_s4[i] <= mag_s3[i] * mag_s3[i];
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			deg_s4 <= deg_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sum_s5 <= SQ_W'(sq_s4[0]) + SQ_W'(sq_s4[1]) + SQ_W'(sq_s4[2]) + SQ_W'(sq_s4[3]);
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
			deg_s5 <= deg_s4;
		end
	end

	assign sum = sum_s5;
	assign mag = mag_s5;
	assign neg = neg_s5;
	assign deg = deg_s5;

endmodule

// ===== hdl/affine_matrix_decompose_top.sv =====
// Pipeline: an accepted request passes 136 pipeline stages and then the output register to m_tvalid.
// Throughput: one matrix per cycle while the skid entry is empty; the two square roots
// and the divider banks are fully pipelined, one result bit per stage, so nothing iterates.
// Backpressure: a one-entry skid behind the output register; the pipeline freezes while it is full.
// Reset: arst_n clears the valid bits, output and skid flags; payload registers are not reset.
// Depends on amd_pkg, amd_sqrt, amd_div, amd_quat.
module affine_matrix_decompose_top import amd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [383:0] s_tdata,   // col0_x,col0_y,col0_z,col1_x..col1_z,col2_x..col2_z,col3_x..col3_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [319:0] m_tdata,   // trans_x,trans_y,trans_z,quat_w,quat_x,quat_y,quat_z,scale_x,y,z
	output logic [0:0]   m_tuser    // degenerate
);

	localparam int D_MAG  = SQRT_LAT + PRE_LAT - 1;
	localparam int D_LEN  = DIV_LAT + QUAT_LAT + SQRT_LAT + DIV_LAT;
	localparam int D_QDEG = SQRT_LAT + DIV_LAT;

	logic ce;
	logic vld_q [TOTAL_LAT];
	logic [3*DW-1:0] tr_d [TOTAL_LAT];

	logic [8:0][DW-1:0] mag_s1;
	logic [8:0]         neg_s1;
	logic [2*DW-1:0]    sq_s2 [9];
	logic [SQ_W-1:0]    csum_s3 [3];

	logic [8:0][DW-1:0] magd [D_MAG];
	logic [8:0]         negd [D_MAG];
	logic [ROOT_W-1:0]  len [3];
	logic [2:0][DW-1:0] lend [D_LEN];
	logic               colz_d [DIV_LAT];
	logic [8:0][DW-1:0] nvec;

	logic [SQ_W-1:0]    qsum;
	logic [3:0][DW-1:0] qmag;
	logic [3:0]         qneg;
	logic               qdeg;
	logic [3:0][DW-1:0] vmagd [SQRT_LAT];
	logic [3:0]         vnegd [SQRT_LAT];
	logic               qdegd [D_QDEG];
	logic [ROOT_W-1:0]  norm;
	logic               nz_d [DIV_LAT];
	logic [3:0][DW-1:0] quat;

	result_t pipe_res;
	result_t out_q, skid_q;
	logic    out_vld_q, skid_vld_q;

	assign ce       = !skid_vld_q;
	assign s_tready = ce;

	// control: valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_LAT; i++)
				vld_q[i] <= 1'b0;
		end else if (ce) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < TOTAL_LAT; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			tr_d[0] <= s_tdata[383:288];
			for (int i = 1; i < TOTAL_LAT; i++)
				tr_d[i] <= tr_d[i-1];
		end
	end

	// front end: magnitudes, squares, column sums
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 9; i++) begin
				mag_s1[i] <= abs_fix(s_tdata[DW*i +: DW]);
				neg_s1[i] <= s_tdata[DW*i + DW - 1];
				sq_s2[i]  <= mag_s1[i] * mag_s1[i];
			end
			for (int j = 0; j < 3; j++)
				csum_s3[j] <= SQ_W'(sq_s2[3*j]) + SQ_W'(sq_s2[3*j+1]) + SQ_W'(sq_s2[3*j+2]);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			magd[0] <= mag_s1;
			negd[0] <= neg_s1;
			for (int i = 1; i < D_MAG; i++) begin
				magd[i] <= magd[i-1];
				negd[i] <= negd[i-1];
			end
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_col
		amd_sqrt u_len (
			.clk  (clk),
			.ce   (ce),
			.rad  (csum_s3[j]),
			.root (len[j])
		);
		for (genvar k = 0; k < 3; k++) begin : g_cmp
			amd_div u_unit (
				.clk (clk),
				.ce  (ce),
				.num (ROOT_W'(magd[D_MAG-1][3*j+k])),
				.neg (negd[D_MAG-1][3*j+k]),
				.den (len[j]),
				.quo (nvec[3*j+k])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			lend[0]   <= {len[2][DW-1:0], len[1][DW-1:0], len[0][DW-1:0]};
			colz_d[0] <= (len[0] == '0) || (len[1] == '0) || (len[2] == '0);
			for (int i = 1; i < D_LEN; i++)
				lend[i] <= lend[i-1];
			for (int i = 1; i < DIV_LAT; i++)
				colz_d[i] <= colz_d[i-1];
		end
	end

	amd_quat u_quat (
		.clk    (clk),
		.ce     (ce),
		.n      (nvec),
		.deg_in (colz_d[DIV_LAT-1]),
		.sum    (qsum),
		.mag    (qmag),
		.neg    (qneg),
		.deg    (qdeg)
	);

	amd_sqrt u_norm (
		.clk  (clk),
		.ce   (ce),
		.rad  (qsum),
		.root (norm)
	);

	always_ff @(posedge clk) begin
		if (ce) begin
			vmagd[0] <= qmag;
			vnegd[0] <= qneg;
			for (int i = 1; i < SQRT_LAT; i++) begin
				vmagd[i] <= vmagd[i-1];
				vnegd[i] <= vnegd[i-1];
			end
			qdegd[0] <= qdeg;
			for (int i = 1; i < D_QDEG; i++)
				qdegd[i] <= qdegd[i-1];
			nz_d[0] <= (norm == '0);
			for (int i = 1; i < DIV_LAT; i++)
				nz_d[i] <= nz_d[i-1];
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_quat
		amd_div u_qdiv (
			.clk (clk),
			.ce  (ce),
			.num (ROOT_W'(vmagd[SQRT_LAT-1][k])),
			.neg (vnegd[SQRT_LAT-1][k]),
			.den (norm),
			.quo (quat[k])
		);
	end

	always_comb begin
		pipe_res.trans_x = tr_d[TOTAL_LAT-1][DW-1:0];
		pipe_res.trans_y = tr_d[TOTAL_LAT-1][2*DW-1:DW];
		pipe_res.trans_z = tr_d[TOTAL_LAT-1][3*DW-1:2*DW];
		pipe_res.quat_w  = quat[0];
		pipe_res.quat_x  = quat[1];
		pipe_res.quat_y  = quat[2];
		pipe_res.quat_z  = quat[3];
		pipe_res.scale_x = lend[D_LEN-1][0];
		pipe_res.scale_y = lend[D_LEN-1][1];
		pipe_res.scale_z = lend[D_LEN-1][2];
		pipe_res.deg     = qdegd[D_QDEG-1] | nz_d[DIV_LAT-1];
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_q[TOTAL_LAT-1];
			end
		end else if (vld_q[TOTAL_LAT-1]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_q <= skid_vld_q ? skid_q : pipe_res;
		end else if (ce && vld_q[TOTAL_LAT-1]) begin
			skid_q <= pipe_res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_q.scale_z, out_q.scale_y, out_q.scale_x, out_q.quat_z, out_q.quat_y,
		out_q.quat_x, out_q.quat_w, out_q.trans_z, out_q.trans_y, out_q.trans_x};
	assign m_tuser  = out_q.deg;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q) else $error("skid holds data with empty output");

	a_skid_catch: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !m_tready && ce && vld_q[TOTAL_LAT-1] |=> skid_vld_q)
		else $error("stalled result was not captured");

	a_zero_scale_deg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (out_q.scale_x == '0 || out_q.scale_y == '0 || out_q.scale_z == '0)
		|-> out_q.deg) else $error("zero column length without degenerate flag");

	a_zero_quat_deg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.quat_w == '0 && out_q.quat_x == '0 && out_q.quat_y == '0
		&& out_q.quat_z == '0 |-> out_q.deg) else $error("zero quaternion without degenerate flag");

endmodule
